// ===== rtl/xtea_pkg.sv =====
// shared types and constants for the xtea block cipher
package xtea_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ROUND_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned HALF_W   = ROUND_W + 1;

	localparam logic [WORD_W-1:0]  XTEA_DELTA     = 32'h9E37_79B9;
	localparam logic [ROUND_W-1:0] ROUNDS_DEFAULT = 8'd32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS    = 3'd4;

	// selector codes
	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic phase;
		logic publish;
	} dp_cmd_t;

endpackage

// ===== rtl/xtea_block_cipher.sv =====
// top level of the xtea 64-bit block cipher
// One block is taken at a time. A block is loaded, then each round passes twice through
// the shared half-round unit (each pass updates one 32-bit half), and the block then
// moves into the output register once that register is free. The next block is taken as
// soon as the finished one sits in the output register, even while that result still
// waits to be read. round_count 0 passes the block through. Key words and round count
// must be written by the user only while the block is idle; the block does not enforce it.
module xtea_block_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_wr_en,
	input  logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xtea_pkg::WORD_W-1:0]     cfg_data,
	// input blocks
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [63:0]                     s_axis_tdata,  // word_first, word_second
	input  logic                            s_axis_tuser,  // func
	// result blocks
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata   // result_first, result_second
);

	xtea_pkg::key_set_t               key;
	logic [xtea_pkg::ROUND_W-1:0]     rounds;
	xtea_pkg::dp_cmd_t                cmd;

	xtea_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key),
		.rounds    (rounds)
	);

	xtea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rounds    (rounds),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	xtea_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.key           (key),
		.rounds        (rounds),
		.func          (s_axis_tuser),
		.word_first    (s_axis_tdata[31:0]),
		.word_second   (s_axis_tdata[63:32]),
		.result_first  (m_axis_tdata[31:0]),
		.result_second (m_axis_tdata[63:32])
	);

endmodule

// ===== rtl/xtea_regs.sv =====
// configuration registers: cipher key words and round count
module xtea_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xtea_pkg::WORD_W-1:0]      cfg_data,
	output xtea_pkg::key_set_t               key,
	output logic [xtea_pkg::ROUND_W-1:0]     rounds
);

	xtea_pkg::key_set_t               key_q;
	logic [xtea_pkg::ROUND_W-1:0]     rounds_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			rounds_q <= xtea_pkg::ROUNDS_DEFAULT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				xtea_pkg::CFG_KEY_ZERO:  key_q[0] <= cfg_data;
				xtea_pkg::CFG_KEY_ONE:   key_q[1] <= cfg_data;
				xtea_pkg::CFG_KEY_TWO:   key_q[2] <= cfg_data;
				xtea_pkg::CFG_KEY_THREE: key_q[3] <= cfg_data;
				xtea_pkg::CFG_ROUNDS:    rounds_q <= cfg_data[xtea_pkg::ROUND_W-1:0];
				default: ;
			endcase
		end
	end

	assign key    = key_q;
	assign rounds = rounds_q;

endmodule

// ===== rtl/xtea_dp.sv =====
// xtea datapath: block halves, running sum, half-round unit and output register
module xtea_dp (
	input  logic                           clk,
	input  xtea_pkg::dp_cmd_t              cmd,
	input  xtea_pkg::key_set_t             key,
	input  logic [xtea_pkg::ROUND_W-1:0]   rounds,
	input  logic                           func,
	input  logic [xtea_pkg::WORD_W-1:0]    word_first,
	input  logic [xtea_pkg::WORD_W-1:0]    word_second,
	output logic [xtea_pkg::WORD_W-1:0]    result_first,
	output logic [xtea_pkg::WORD_W-1:0]    result_second
);

	localparam int unsigned PROD_W = xtea_pkg::WORD_W + xtea_pkg::ROUND_W;

	logic [xtea_pkg::WORD_W-1:0] v0_q, v1_q, sum_q, res0_q, res1_q;
	logic                        dec_q;

	logic                        tgt_is_v0;
	logic [xtea_pkg::WORD_W-1:0] src, tgt, mixed, key_sum, f_val, new_val;
	logic [1:0]                  kidx;
	logic [PROD_W-1:0]           start_prod;

	// decipher starts at delta times the round count
	assign start_prod = PROD_W'(xtea_pkg::XTEA_DELTA) * PROD_W'(rounds);

	// first half of a round updates v0 on encipher and v1 on decipher
	assign tgt_is_v0 = ~(cmd.phase ^ dec_q);
	assign src       = tgt_is_v0 ? v1_q : v0_q;
	assign tgt       = tgt_is_v0 ? v0_q : v1_q;
	assign kidx      = tgt_is_v0 ? sum_q[1:0] : sum_q[12:11];

	// round function: shift mix plus keyed sum
	assign mixed   = ((src << 4) ^ (src >> 5)) + src;
	assign key_sum = sum_q + key[kidx];
	assign f_val   = mixed ^ key_sum;
	assign new_val = dec_q ? (tgt - f_val) : (tgt + f_val);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v0_q  <= word_first;
			v1_q  <= word_second;
			dec_q <= func;
			sum_q <= (func == xtea_pkg::FUNC_DEC) ? start_prod[xtea_pkg::WORD_W-1:0] : '0;
		end else if (cmd.step) begin
			if (tgt_is_v0) begin
				v0_q <= new_val;
			end else begin
				v1_q <= new_val;
			end
			// sum moves between the two halves of a round
			if (!cmd.phase) begin
				sum_q <= dec_q ? (sum_q - xtea_pkg::XTEA_DELTA) : (sum_q + xtea_pkg::XTEA_DELTA);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res0_q <= v0_q;
			res1_q <= v1_q;
		end
	end

	assign result_first  = res0_q;
	assign result_second = res1_q;

endmodule

// ===== rtl/xtea_ctrl.sv =====
// xtea controller: input handshake, half-round sequencing, output valid
module xtea_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [xtea_pkg::ROUND_W-1:0]  rounds,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output xtea_pkg::dp_cmd_t             cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} state_t;

	state_t                        state_q;
	logic [xtea_pkg::HALF_W-1:0]   cnt_q;
	logic                          phase_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign out_free = ~out_valid_q | out_ready;

	// commands to the datapath
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) & in_valid;
		cmd.step    = (state_q == S_RUN);
		cmd.phase   = phase_q;
		cmd.publish = (state_q == S_HOLD) & out_free;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// state, half-round counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= {rounds, 1'b0};
						phase_q <= 1'b0;
						state_q <= (rounds == '0) ? S_HOLD : S_RUN;
					end
				end
				S_RUN: begin
					cnt_q   <= cnt_q - 1'b1;
					phase_q <= ~phase_q;
					if (cnt_q == xtea_pkg::HALF_W'(1)) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sim/xtea_block_cipher_tb.sv =====
// self-checking testbench for the xtea block cipher: stream stimulus, round predictor, scoreboard
module xtea_block_cipher_tb;
	import xtea_pkg::*;

	// expected results of accepted blocks, worked out from a mirror of the key and round count
	class xtea_block_ledger;
		logic [WORD_W-1:0]  key [KEY_WORDS];
		logic [ROUND_W-1:0] rounds;
		logic [63:0]        expected_blocks [$];
		int                 errors;
		int                 blocks_in;
		int                 blocks_out;

		function new();
			foreach (key[i]) key[i] = '0;
			rounds = ROUNDS_DEFAULT;
			errors = 0;
			blocks_in = 0;
			blocks_out = 0;
		endfunction

		// mirror one register write, unknown indexes change nothing
		function void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
			case (idx)
				CFG_KEY_ZERO, CFG_KEY_ONE, CFG_KEY_TWO, CFG_KEY_THREE: key[idx[1:0]] = data;
				CFG_ROUNDS: rounds = data[ROUND_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [WORD_W-1:0] mix(logic [WORD_W-1:0] x);
			return ((x << 4) ^ (x >> 5)) + x;
		endfunction

		// full feistel run, result packed as {second, first}
		function logic [63:0] xtea_rounds(logic f, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			logic [WORD_W-1:0] v0, v1, sum;
			v0 = a;
			v1 = b;
			if (f == FUNC_ENC) begin
				sum = '0;
				for (int r = 0; r < rounds; r++) begin
					v0 += mix(v1) ^ (sum + key[sum[1:0]]);
					sum += XTEA_DELTA;
					v1 += mix(v0) ^ (sum + key[sum[12:11]]);
				end
			end else begin
				sum = XTEA_DELTA * rounds;
				for (int r = 0; r < rounds; r++) begin
					v1 -= mix(v0) ^ (sum + key[sum[12:11]]);
					sum -= XTEA_DELTA;
					v0 -= mix(v1) ^ (sum + key[sum[1:0]]);
				end
			end
			return {v1, v0};
		endfunction

		function void note_block(logic f, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			expected_blocks.push_back(xtea_rounds(f, a, b));
			blocks_in++;
		endfunction

		function void check_block(logic [63:0] got);
			logic [63:0] want;
			blocks_out++;
			if (expected_blocks.size() == 0) begin
				$error("result beat with no block pending: %h", got);
				errors++;
				return;
			end
			want = expected_blocks.pop_front();
			if (got[31:0] !== want[31:0]) begin
				$error("result_first: expected %h, got %h", want[31:0], got[31:0]);
				errors++;
			end
			if (got[63:32] !== want[63:32]) begin
				$error("result_second: expected %h, got %h", want[63:32], got[63:32]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata;  // word_first, word_second
	logic                 s_axis_tuser;  // func
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [63:0]          m_axis_tdata;  // result_first, result_second

	xtea_block_ledger ledger;
	logic             gaps_on;
	int               hold_left;
	int               settings_used;

	xtea_block_cipher u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls, long hold on request, check every beat
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(gaps_on && $urandom_range(99) < 16);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				ledger.check_block(m_axis_tdata);
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ledger.mirror_write(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// offer one block, valid stays high afterwards until the next falling edge
	task automatic send_block(input logic f, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		while (gaps_on && $urandom_range(99) < 16) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		s_axis_tuser  <= f;
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_block(f, a, b);
	endtask

	// stop offering and wait for every pending result
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (ledger.expected_blocks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// word with a bias toward the extremes
	function automatic logic [WORD_W-1:0] pick_word();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return '0;
		if (roll < 12)
			return '1;
		return $urandom();
	endfunction

	// random key and round count: mostly short runs, now and then long ones (128 to 255) or zero
	task automatic pick_settings();
		logic [WORD_W-1:0]  data;
		logic [ROUND_W-1:0] r;
		int unsigned        roll;
		for (int k = 0; k < KEY_WORDS; k++)
			cfg_write(CFG_IDX_W'(CFG_KEY_ZERO + k), pick_word());
		roll = $urandom_range(99);
		if (roll < 5)
			r = '0;
		else if (roll < 12)
			r = ROUND_W'($urandom_range(128, 255));
		else if (roll < 25)
			r = ROUNDS_DEFAULT;
		else
			r = ROUND_W'($urandom_range(1, 40));
		data = $urandom();
		if ($urandom_range(99) >= 30)
			data[WORD_W-1:ROUND_W] = '0;
		data[ROUND_W-1:0] = r;
		cfg_write(CFG_ROUNDS, data);
		// writes to indexes past the register list must leave everything alone
		if ($urandom_range(99) < 20)
			cfg_write(CFG_IDX_W'($urandom_range(CFG_ROUNDS + 1, 2**CFG_IDX_W - 1)), $urandom());
		settings_used++;
	endtask

	// main sequence
	initial begin
		logic [WORD_W-1:0] a, b;
		logic [63:0]       c;
		int                n_items;

		ledger        = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_ENC;
		m_axis_tready = 1'b0;
		gaps_on       = 1'b1;
		hold_left     = 0;
		settings_used = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset key and default round count
		send_block(FUNC_ENC, '0, '0);
		send_block(FUNC_DEC, '0, '0);
		send_block(FUNC_ENC, '1, '1);
		send_block(FUNC_DEC, '1, '1);
		wait_drained();

		// all-ones key, default rounds, round trip through decipher
		cfg_write(CFG_KEY_ZERO, '1);
		cfg_write(CFG_KEY_ONE, '1);
		cfg_write(CFG_KEY_TWO, '1);
		cfg_write(CFG_KEY_THREE, '1);
		cfg_write(CFG_ROUNDS, WORD_W'(ROUNDS_DEFAULT));
		settings_used++;
		send_block(FUNC_ENC, '0, '1);
		send_block(FUNC_DEC, '1, '0);
		a = $urandom();
		b = $urandom();
		c = ledger.xtea_rounds(FUNC_ENC, a, b);
		send_block(FUNC_DEC, c[31:0], c[63:32]);
		wait_drained();

		// zero rounds pass the block through
		cfg_write(CFG_ROUNDS, '0);
		settings_used++;
		send_block(FUNC_ENC, $urandom(), $urandom());
		send_block(FUNC_DEC, $urandom(), $urandom());
		wait_drained();

		// single round
		cfg_write(CFG_ROUNDS, 32'd1);
		settings_used++;
		send_block(FUNC_ENC, $urandom(), $urandom());
		send_block(FUNC_DEC, $urandom(), $urandom());
		wait_drained();

		// longest round count
		cfg_write(CFG_ROUNDS, 32'd255);
		settings_used++;
		send_block(FUNC_ENC, $urandom(), $urandom());
		send_block(FUNC_DEC, $urandom(), $urandom());
		wait_drained();

		// upper data bits ignored for the round count, unknown indexes ignored
		cfg_write(CFG_ROUNDS, 32'hFFFF_FF07);
		for (int i = CFG_ROUNDS + 1; i < 2**CFG_IDX_W; i++)
			cfg_write(CFG_IDX_W'(i), $urandom());
		settings_used++;
		send_block(FUNC_ENC, $urandom(), $urandom());
		wait_drained();

		// alternating key bits
		cfg_write(CFG_KEY_ZERO, 32'hAAAA_AAAA);
		cfg_write(CFG_KEY_ONE, 32'h5555_5555);
		cfg_write(CFG_KEY_TWO, 32'hAAAA_AAAA);
		cfg_write(CFG_KEY_THREE, 32'h5555_5555);
		cfg_write(CFG_ROUNDS, WORD_W'(ROUNDS_DEFAULT));
		settings_used++;
		send_block(FUNC_ENC, 32'h0123_4567, 32'h89AB_CDEF);
		send_block(FUNC_DEC, 32'h89AB_CDEF, 32'h0123_4567);
		wait_drained();

		// random phases
		for (int p = 0; p < 21; p++) begin
			pick_settings();
			n_items = (ledger.rounds >= 128) ? 8 : 50;
			gaps_on = (p != 4);
			if (p == 1)
				hold_left = 400;
			for (int i = 0; i < n_items; i++) begin
				if (p == 6 && i == n_items / 2)
					wait_drained();
				a = pick_word();
				b = pick_word();
				if ($urandom_range(99) < 30) begin
					// decipher a fresh ciphertext so the pair really inverts
					c = ledger.xtea_rounds(FUNC_ENC, a, b);
					send_block(FUNC_DEC, c[31:0], c[63:32]);
				end else begin
					send_block(1'($urandom_range(1)), a, b);
				end
			end
			wait_drained();
		end

		// quiet time to catch stray results
		repeat (2 * 255 + 8) @(posedge clk);
		$display("blocks sent %0d, results checked %0d, under %0d key and round settings",
			ledger.blocks_in, ledger.blocks_out, settings_used);
		$display("rounds from 0 to 255, both directions, long output hold and full drain");
		if (ledger.errors == 0 && ledger.expected_blocks.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
